// ----- rtl/core/arpc_pkg.sv -----
// Shared types, constants and helpers for the ARP cache table.
`timescale 1ns / 1ps

package arpc_pkg;

    // Table geometry
    localparam int ENTRIES = 4;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 6;

    // Reset value of the insertion age register, in seconds
    localparam logic [TIME_W-1:0] RESET_AGE = TIME_W'(1800);

    // Broadcast mapping held in entry 0 after reset
    localparam logic [IP_W-1:0]  BCAST_IP  = '1;
    localparam logic [MAC_W-1:0] BCAST_MAC = '1;

    // Request codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_PUT    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr_req;

    // Contents of an entry that has not been written since reset
    function automatic t_entry reset_entry(input logic is_slot0);
        t_entry e;
        e.ip    = is_slot0 ? BCAST_IP  : '0;
        e.mac   = is_slot0 ? BCAST_MAC : '0;
        e.stamp = '0;
        return e;
    endfunction

endpackage

// ----- rtl/core/arp_cache_lru_table.sv -----
// Top level of the ARP cache table: sequencer plus entry memory.
`timescale 1ns / 1ps

// Small IP-to-MAC cache with ENTRIES slots; slot 0 holds the broadcast mapping
// after reset and unused slots carry IP 0.0.0.0. A request is taken when start
// is high and busy is low. Each request reads every entry once through the
// single memory read port in the scan state, then does the write-back in the
// write state; busy stays high until the block is back in idle. The result
// beat appears on o_res_valid for exactly one cycle, in the cycle after the
// write-back; it cannot be held, so the receiver must take it then. The
// insertion age register is written through the cfg channel while busy is
// low; o_cfg_ready is the inverse of busy.
module arp_cache_lru_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_action,
    input  logic [arpc_pkg::IP_W-1:0]   i_ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]  i_mac_in,
    input  logic [arpc_pkg::TIME_W-1:0] i_now,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [arpc_pkg::TIME_W-1:0] i_cfg_data,
    output logic                        o_res_valid,
    output logic                        o_hit,
    output logic [arpc_pkg::SLOT_W-1:0] o_slot,
    output logic [arpc_pkg::MAC_W-1:0]  o_mac_out
);
    import arpc_pkg::*;

    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    t_wr_req          wr_req;

    arpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_ip_addr   (i_ip_addr),
        .i_mac_in    (i_mac_in),
        .i_now       (i_now),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr        (wr_req),
        .o_res_valid (o_res_valid),
        .o_hit       (o_hit),
        .o_slot      (o_slot),
        .o_mac_out   (o_mac_out)
    );

    arpc_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr_req)
    );

    // An accepted request keeps the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Result beats are single-cycle and never back to back
    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe held for more than one cycle");

    // A miss never returns a MAC
    a_miss_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_hit) |-> (o_mac_out == '0))
        else $error("miss carried a non-zero MAC");

    // Memory is written only in the cycle before a result beat
    a_wr_then_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |=> o_res_valid)
        else $error("write-back not followed by a result beat");

endmodule

// ----- rtl/core/arpc_store.sv -----
// Entry memory with one registered read port, one write port and reset valid bits.
`timescale 1ns / 1ps

module arpc_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [arpc_pkg::IDX_W-1:0] i_rd_addr,
    output arpc_pkg::t_entry       o_rd_data,
    input  arpc_pkg::t_wr_req      i_wr
);
    import arpc_pkg::*;

    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_entry             r_rd_raw;
    logic               r_rd_valid;
    logic               r_rd_slot0;

    // Write and registered read of the entry array
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_raw   <= r_mem[i_rd_addr];
        r_rd_slot0 <= (i_rd_addr == '0);
    end

    // Track which entries hold written data; reset drops them all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // Substitute the reset contents for an entry never written
    assign o_rd_data = r_rd_valid ? r_rd_raw : reset_entry(r_rd_slot0);

endmodule

// ----- rtl/core/arpc_ctrl.sv -----
// Request sequencer: scans the entries, picks the target and writes back.
`timescale 1ns / 1ps

module arpc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_action,
    input  logic [arpc_pkg::IP_W-1:0]   i_ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]  i_mac_in,
    input  logic [arpc_pkg::TIME_W-1:0] i_now,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [arpc_pkg::TIME_W-1:0] i_cfg_data,
    output logic [arpc_pkg::IDX_W-1:0]  o_rd_addr,
    input  arpc_pkg::t_entry            i_rd_data,
    output arpc_pkg::t_wr_req           o_wr,
    output logic                        o_res_valid,
    output logic                        o_hit,
    output logic [arpc_pkg::SLOT_W-1:0] o_slot,
    output logic [arpc_pkg::MAC_W-1:0]  o_mac_out
);
    import arpc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

    t_state r_state, n_state;

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_action;
    logic [IP_W-1:0]   r_ip;
    logic [MAC_W-1:0]  r_mac;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_age;

    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_match, n_match;
    logic [MAC_W-1:0]  r_match_mac, n_match_mac;
    logic              r_free_found, n_free_found;
    logic [IDX_W-1:0]  r_free, n_free;
    logic [IDX_W-1:0]  r_best, n_best;
    logic [TIME_W-1:0] r_best_stamp, n_best_stamp;

    logic              r_res_valid, n_res_valid;
    logic              r_hit, n_hit;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [MAC_W-1:0]  r_mac_out, n_mac_out;

    logic              accept;
    logic [TIME_W-1:0] stamp_diff;
    logic [IDX_W-1:0]  put_idx;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;
    assign stamp_diff  = i_rd_data.stamp - r_best_stamp;
    assign put_idx     = r_found ? r_match : (r_free_found ? r_free : r_best);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Read address, scan bookkeeping, write-back and result
    always_comb begin
        o_rd_addr    = '0;
        n_idx        = r_idx;
        n_found      = r_found;
        n_match      = r_match;
        n_match_mac  = r_match_mac;
        n_free_found = r_free_found;
        n_free       = r_free;
        n_best       = r_best;
        n_best_stamp = r_best_stamp;
        o_wr         = '0;
        n_res_valid  = 1'b0;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_mac_out    = r_mac_out;
        unique case (r_state)
            ST_IDLE: begin
                o_rd_addr    = '0;
                n_idx        = '0;
                n_found      = 1'b0;
                n_free_found = 1'b0;
            end
            ST_SCAN: begin
                // Fetch the next entry while the current one is judged
                o_rd_addr = r_idx + IDX_ONE;
                n_idx     = r_idx + IDX_ONE;
                if (!r_found && (i_rd_data.ip == r_ip)) begin
                    n_found     = 1'b1;
                    n_match     = r_idx;
                    n_match_mac = i_rd_data.mac;
                end
                if (!r_free_found && (r_idx != '0) && (i_rd_data.ip == '0)) begin
                    n_free_found = 1'b1;
                    n_free       = r_idx;
                end
                // Oldest stamp by wrap-aware difference; ties keep the lower slot
                if (r_idx == IDX_ONE) begin
                    n_best       = r_idx;
                    n_best_stamp = i_rd_data.stamp;
                end else if ((r_idx > IDX_ONE) && stamp_diff[TIME_W-1]) begin
                    n_best       = r_idx;
                    n_best_stamp = i_rd_data.stamp;
                end
            end
            ST_WRITE: begin
                n_res_valid = 1'b1;
                n_hit       = r_found;
                if (r_action == ACT_PUT) begin
                    o_wr.en         = 1'b1;
                    o_wr.addr       = put_idx;
                    o_wr.data.ip    = r_ip;
                    o_wr.data.mac   = r_mac;
                    o_wr.data.stamp = r_now - r_age;
                    n_slot          = SLOT_W'(put_idx);
                    n_mac_out       = '0;
                end else begin
                    // Lookup: restamp a hit, leave the table alone on a miss
                    o_wr.en         = r_found;
                    o_wr.addr       = r_match;
                    o_wr.data.ip    = r_ip;
                    o_wr.data.mac   = r_match_mac;
                    o_wr.data.stamp = r_now;
                    n_slot          = r_found ? SLOT_W'(r_match) : '0;
                    n_mac_out       = r_found ? r_match_mac : '0;
                end
            end
            default: begin
                o_rd_addr = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
            r_age       <= RESET_AGE;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_age <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_ip     <= i_ip_addr;
            r_mac    <= i_mac_in;
            r_now    <= i_now;
        end
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_match      <= n_match;
        r_match_mac  <= n_match_mac;
        r_free_found <= n_free_found;
        r_free       <= n_free;
        r_best       <= n_best;
        r_best_stamp <= n_best_stamp;
        r_hit        <= n_hit;
        r_slot       <= n_slot;
        r_mac_out    <= n_mac_out;
    end

    assign o_res_valid = r_res_valid;
    assign o_hit       = r_hit;
    assign o_slot      = r_slot;
    assign o_mac_out   = r_mac_out;

endmodule

// ----- verif/tb_arp_cache_lru_table.sv -----
// Self-checking testbench for the ARP cache table: driven requests, shadow table, reply check.
`timescale 1ns / 1ps

module tb_arp_cache_lru_table;

    import arpc_pkg::*;

    typedef struct packed {
        logic              action;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] now;
    } t_arp_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [MAC_W-1:0]  mac;
    } t_arp_reply;

    localparam int POOL_N     = 6;
    localparam int RAND_ITEMS = 250;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic                i_action    = ACT_LOOKUP;
    logic [IP_W-1:0]     i_ip_addr   = '0;
    logic [MAC_W-1:0]    i_mac_in    = '0;
    logic [TIME_W-1:0]   i_now       = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [TIME_W-1:0]   i_cfg_data  = '0;
    logic                o_res_valid;
    logic                o_hit;
    logic [SLOT_W-1:0]   o_slot;
    logic [MAC_W-1:0]    o_mac_out;

    // Stimulus and prediction state
    t_arp_req            pending_reqs[$];
    t_arp_reply          expected_replies[$];
    t_entry              shadow_tbl[ENTRIES];
    logic [TIME_W-1:0]   insert_age  = RESET_AGE;
    logic [IP_W-1:0]     ip_pool[POOL_N];
    logic [TIME_W-1:0]   clock_s     = '0;
    int                  idle_pct    = 0;
    int                  mismatch_cnt = 0;

    arp_cache_lru_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_ip_addr   (i_ip_addr),
        .i_mac_in    (i_mac_in),
        .i_now       (i_now),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_hit       (o_hit),
        .o_slot      (o_slot),
        .o_mac_out   (o_mac_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Choose the slot a put takes on a miss: first unused from slot 1, else the oldest stamp
    function automatic int victim_slot();
        int best;
        logic [TIME_W-1:0] best_stamp;
        logic [TIME_W-1:0] diff;
        best = 1;
        best_stamp = shadow_tbl[1].stamp;
        for (int i = 1; i < ENTRIES; i++) begin
            if (shadow_tbl[i].ip == '0)
                return i;
            diff = shadow_tbl[i].stamp - best_stamp;
            if (diff[TIME_W-1]) begin
                best = i;
                best_stamp = shadow_tbl[i].stamp;
            end
        end
        return best;
    endfunction

    // Apply one request to the shadow table and return the reply it produces
    function automatic t_arp_reply cache_apply(input t_arp_req rq);
        int idx;
        t_arp_reply r;
        idx = -1;
        r = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (idx < 0 && shadow_tbl[i].ip == rq.ip)
                idx = i;
        if (rq.action == ACT_LOOKUP) begin
            if (idx >= 0) begin
                shadow_tbl[idx].stamp = rq.now;
                r.hit  = 1'b1;
                r.slot = SLOT_W'(idx);
                r.mac  = shadow_tbl[idx].mac;
            end
        end else begin
            r.hit = (idx >= 0);
            if (idx < 0)
                idx = victim_slot();
            shadow_tbl[idx].ip    = rq.ip;
            shadow_tbl[idx].mac   = rq.mac;
            shadow_tbl[idx].stamp = rq.now - insert_age;
            r.slot = SLOT_W'(idx);
        end
        return r;
    endfunction

    function automatic t_arp_req mk_req(input logic act, input logic [IP_W-1:0] ip,
                                        input logic [MAC_W-1:0] mac,
                                        input logic [TIME_W-1:0] now);
        t_arp_req rq;
        rq.action = act;
        rq.ip     = ip;
        rq.mac    = mac;
        rq.now    = now;
        return rq;
    endfunction

    // Mostly a small pool of addresses so entries hit and get evicted; some noise
    function automatic t_arp_req random_req();
        t_arp_req rq;
        int sel;
        rq.action = 1'($urandom_range(1));
        sel = $urandom_range(99);
        if (sel < 78)
            rq.ip = ip_pool[$urandom_range(POOL_N-1)];
        else if (sel < 84)
            rq.ip = '0;
        else if (sel < 90)
            rq.ip = BCAST_IP;
        else
            rq.ip = $urandom;
        sel = $urandom_range(99);
        if (sel < 5)
            rq.mac = '0;
        else if (sel < 10)
            rq.mac = '1;
        else
            rq.mac = MAC_W'({$urandom, $urandom});
        // Advance the time base; now and then jump far or go backwards
        sel = $urandom_range(99);
        if (sel < 85)
            clock_s = clock_s + $urandom_range(3000);
        else if (sel < 95)
            clock_s = clock_s + $urandom;
        else
            clock_s = $urandom;
        rq.now = clock_s;
        return rq;
    endfunction

    // Wait until every request is taken and every reply is back, then let the block settle
    task automatic drain();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || start || expected_replies.size() != 0);
        repeat (ENTRIES + 4) @(negedge i_clk);
    endtask

    task automatic write_age(input logic [TIME_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        insert_age = v;
    endtask

    // Driver: present queued requests, predict each one as it is accepted
    always @(posedge i_clk) begin : drive_blk
        logic accepted;
        logic hold;
        logic go;
        if (!i_rst_n) begin
            start <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                shadow_tbl[i].ip    = (i == 0) ? '1 : '0;
                shadow_tbl[i].mac   = (i == 0) ? '1 : '0;
                shadow_tbl[i].stamp = '0;
            end
        end else begin
            accepted = start && !busy;
            if (accepted)
                expected_replies.push_back(cache_apply(pending_reqs.pop_front()));
            hold = start && !accepted;
            go = hold || (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct);
            if (go && !hold) begin
                i_action  <= pending_reqs[0].action;
                i_ip_addr <= pending_reqs[0].ip;
                i_mac_in  <= pending_reqs[0].mac;
                i_now     <= pending_reqs[0].now;
            end
            start <= go;
        end
    end

    // Monitor: check each reply beat against the oldest prediction
    always @(posedge i_clk) begin : check_blk
        t_arp_reply exp_r;
        if (i_rst_n && o_res_valid) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected reply beat: hit %0d slot %0d mac %h",
                       o_hit, o_slot, o_mac_out);
                mismatch_cnt++;
            end else begin
                exp_r = expected_replies.pop_front();
                if (o_hit !== exp_r.hit) begin
                    $error("hit: expected %0d, got %0d", exp_r.hit, o_hit);
                    mismatch_cnt++;
                end
                if (o_slot !== exp_r.slot) begin
                    $error("slot: expected %0d, got %0d", exp_r.slot, o_slot);
                    mismatch_cnt++;
                end
                if (o_mac_out !== exp_r.mac) begin
                    $error("mac_out: expected %h, got %h", exp_r.mac, o_mac_out);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Stimulus sequence: directed checks, then random phases at several ages and idle rates
    initial begin : stim_blk
        logic [TIME_W-1:0] ages[5];
        int idles[5];
        ages[0]  = '0;
        ages[1]  = '1;
        ages[2]  = 32'd1;
        ages[3]  = $urandom;
        ages[4]  = 32'h8000_0000;
        idles[0] = 0;
        idles[1] = 68;
        idles[2] = 24;
        idles[3] = 0;
        idles[4] = 68;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: broadcast, zero address, fill, evict, update, overwrite slot 0
        pending_reqs.push_back(mk_req(ACT_LOOKUP, BCAST_IP, '0, 32'd100));
        pending_reqs.push_back(mk_req(ACT_LOOKUP, '0, '1, 32'd100));
        pending_reqs.push_back(mk_req(ACT_LOOKUP, 32'h0A00_0001, '0, 32'd100));
        pending_reqs.push_back(mk_req(ACT_PUT, 32'h0A00_0001, '0, 32'd0));
        pending_reqs.push_back(mk_req(ACT_PUT, 32'h0A00_0002, '1, '1));
        pending_reqs.push_back(mk_req(ACT_PUT, 32'hC0A8_0001, 48'h0123_4567_89AB, 32'd5000));
        pending_reqs.push_back(mk_req(ACT_PUT, '0, 48'hA5A5_5A5A_0F0F, 32'd5000));
        pending_reqs.push_back(mk_req(ACT_LOOKUP, '0, '0, 32'd5001));
        pending_reqs.push_back(mk_req(ACT_PUT, 32'h0A00_0003, 48'h0000_0000_0001, 32'd5002));
        pending_reqs.push_back(mk_req(ACT_LOOKUP, 32'h0A00_0001, '0, 32'd6000));
        pending_reqs.push_back(mk_req(ACT_PUT, 32'h0A00_0001, 48'h8000_0000_0000, 32'd6001));
        pending_reqs.push_back(mk_req(ACT_PUT, BCAST_IP, 48'h0011_2233_4455, 32'd6002));
        pending_reqs.push_back(mk_req(ACT_LOOKUP, BCAST_IP, '0, 32'd6003));
        pending_reqs.push_back(mk_req(ACT_PUT, 32'h0B00_0000, 48'h7FFF_FFFF_FFFF, 32'hFFFF_0000));
        pending_reqs.push_back(mk_req(ACT_LOOKUP, 32'h0B00_0000, '0, '0));
        pending_reqs.push_back(mk_req(ACT_LOOKUP, 32'hFFFF_FFFE, '1, '1));
        pending_reqs.push_back(mk_req(ACT_PUT, 32'h8000_0000, '1, 32'h7FFF_FFFF));
        pending_reqs.push_back(mk_req(ACT_LOOKUP, 32'h8000_0000, '0, 32'h8000_0000));
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_age(ages[ph]);
            idle_pct = idles[ph];
            ip_pool[0] = $urandom;
            for (int k = 1; k < POOL_N; k++)
                ip_pool[k] = $urandom;
            @(negedge i_clk);
            for (int n = 0; n < RAND_ITEMS; n++)
                pending_reqs.push_back(random_req());
            drain();
        end

        if (mismatch_cnt == 0 && expected_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop if the handshakes never complete
    initial begin
        #500000;
        $display("status: fail");
        $finish;
    end

endmodule
